// ----- rtl/core/rc5_pkg.sv -----
// Shared types and constants for the RC5 IR pulse decoder.
// No dependencies; rc5_cfg, rc5_step and the top level import this package.
package rc5_pkg;

  // Result status codes.
  localparam logic [2:0] ST_ACK     = 3'd0;
  localparam logic [2:0] ST_START   = 3'd1;
  localparam logic [2:0] ST_HALF    = 3'd2;
  localparam logic [2:0] ST_DONE    = 3'd3;
  localparam logic [2:0] ST_RESTART = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] REG_SPIKE_LIM = 2'd0;
  localparam logic [1:0] REG_HALF_LIM  = 2'd1;
  localparam logic [1:0] REG_MAX_BIT   = 2'd2;

  // Configuration reset values in timer ticks.
  localparam logic [15:0] SPIKE_LIM_RST = 16'd400;
  localparam logic [15:0] HALF_LIM_RST  = 16'd1300;
  localparam logic [15:0] MAX_BIT_RST   = 16'd2200;

  // Frame layout: command in bits 5..0, address in 10..6, toggle at bit 11.
  localparam int          FRAME_BITS  = 13;
  localparam logic [3:0]  LAST_BIT    = 4'd12;
  localparam logic [3:0]  BITS_MAX    = 4'd13;

  // Threshold registers.
  typedef struct packed {
    logic [15:0] spike_lim;
    logic [15:0] half_lim;
    logic [15:0] max_bit;
  } rc5_cfg_t;

  // Decoder state carried from one edge to the next.
  typedef struct packed {
    logic [4:0]            phase;
    logic [FRAME_BITS-1:0] shift;
    logic [3:0]            bits;
    logic                  key;
    logic [5:0]            command;
    logic [4:0]            address;
    logic                  toggle;
  } rc5_state_t;

endpackage

// ----- rtl/core/rc5_in_if.sv -----
// Input request channel of the RC5 decoder: one line edge or acknowledge.
// Depends on nothing.
interface rc5_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] pulse_width;
  logic        edge_rising;

  modport source (output valid, output kind, output pulse_width, output edge_rising,
                  input ready);
  modport sink   (input valid, input kind, input pulse_width, input edge_rising,
                  output ready);
endinterface

// ----- rtl/core/rc5_out_if.sv -----
// Result request channel of the RC5 decoder: status and latched key fields.
// Depends on nothing.
interface rc5_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic       key_ready;
  logic [5:0] rc_command;
  logic [4:0] rc_address;
  logic       toggle;

  modport source (output valid, output status, output key_ready, output rc_command,
                  output rc_address, output toggle, input ready);
  modport sink   (input valid, input status, input key_ready, input rc_command,
                  input rc_address, input toggle, output ready);
endinterface

// ----- rtl/core/rc5_cfg.sv -----
// Threshold register file of the RC5 decoder.
// Depends on rc5_pkg.
module rc5_cfg
  import rc5_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [1:0]  index,
  input  logic [15:0] wdata,
  output rc5_cfg_t    cfg
);

  rc5_cfg_t cfg_r;

  // Write one register; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.spike_lim <= SPIKE_LIM_RST;
      cfg_r.half_lim  <= HALF_LIM_RST;
      cfg_r.max_bit   <= MAX_BIT_RST;
    end else if (wr_en) begin
      unique case (index)
        REG_SPIKE_LIM: cfg_r.spike_lim <= wdata;
        REG_HALF_LIM:  cfg_r.half_lim  <= wdata;
        REG_MAX_BIT:   cfg_r.max_bit   <= wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/core/rc5_step.sv -----
// Next-state logic of the RC5 decoder for one request.
// Depends on rc5_pkg; purely combinational.
module rc5_step
  import rc5_pkg::*;
(
  input  rc5_cfg_t    cfg,
  input  rc5_state_t  cur,
  input  logic        kind,
  input  logic [15:0] pulse_width,
  input  logic        edge_rising,
  output rc5_state_t  nxt,
  output logic [2:0]  status
);

  logic                  gap;
  logic [4:0]            phase_g;
  logic [4:0]            phase_f;
  logic [FRAME_BITS-1:0] shift_n;
  logic [3:0]            bits_n;

  // Interval classification against the thresholds.
  assign gap     = pulse_width > cfg.max_bit;
  assign phase_g = gap ? 5'd0 : cur.phase;
  assign phase_f = (pulse_width > cfg.half_lim) ? phase_g + 5'd1 : phase_g;
  assign shift_n = {cur.shift[FRAME_BITS-2:0], edge_rising};
  assign bits_n  = cur.bits + 4'd1;

  always_comb begin
    nxt    = cur;
    status = ST_HALF;
    if (kind) begin
      // Acknowledge only clears the pending key.
      nxt.key = 1'b0;
      status  = ST_ACK;
    end else if (phase_g == 5'd0) begin
      // Gap or first edge while waiting: start a frame.
      nxt.shift = '0;
      nxt.bits  = '0;
      nxt.phase = 5'd1;
      status    = ST_START;
    end else if (pulse_width < cfg.spike_lim) begin
      // Spike inside a frame.
      nxt.phase = 5'd0;
      status    = ST_RESTART;
    end else if (phase_f > 5'd1 && !phase_f[0]) begin
      // Mid-bit edge: take the direction as a data bit.
      nxt.shift = shift_n;
      nxt.bits  = bits_n;
      if (bits_n > LAST_BIT) begin
        if (!cur.key) begin
          nxt.command = shift_n[5:0];
          nxt.address = shift_n[10:6];
          nxt.toggle  = shift_n[11];
        end
        nxt.key   = 1'b1;
        nxt.phase = 5'd0;
        status    = ST_DONE;
      end else begin
        nxt.phase = phase_f + 5'd1;
      end
    end else begin
      nxt.phase = phase_f + 5'd1;
    end
  end

endmodule

// ----- rtl/core/rc5_ir_pulse_decoder.sv -----
// Top level of the RC5 IR pulse decoder: state and result registers.
// Depends on rc5_pkg, rc5_in_if, rc5_out_if, rc5_cfg and rc5_step.
//
//   Channel | Direction | Carries
//   in_ch   | sink      | kind, pulse_width, edge_rising
//   out_ch  | source    | status, key_ready, rc_command, rc_address, toggle
//   cfg_*   | write     | spike_lim, half_lim, max_bit (index 0..2)
//
// Each request yields one result in the cycle after it is accepted.
// One request per cycle, unless the single result register is full and not drained.
// A request is still taken while a result waits, as long as out_ch.ready is high.
// Synchronous active-low reset clears the decoder state and reloads the thresholds.
module rc5_ir_pulse_decoder
  import rc5_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  rc5_in_if.sink      in_ch,
  rc5_out_if.source   out_ch,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  rc5_cfg_t   cfg;
  rc5_state_t state_r;
  rc5_state_t state_nxt;
  logic [2:0] status_nxt;
  logic [2:0] status_r;
  logic       out_valid_r;
  logic       in_fire;

  rc5_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (cfg_wr_en),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  rc5_step u_step (
    .cfg         (cfg),
    .cur         (state_r),
    .kind        (in_ch.kind),
    .pulse_width (in_ch.pulse_width),
    .edge_rising (in_ch.edge_rising),
    .nxt         (state_nxt),
    .status      (status_nxt)
  );

  // Accept whenever the result register is empty or being drained.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Decoder state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r <= status_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = status_r;
  assign out_ch.key_ready  = state_r.key;
  assign out_ch.rc_command = state_r.command;
  assign out_ch.rc_address = state_r.address;
  assign out_ch.toggle     = state_r.toggle;

  // An acknowledge always reports a cleared key.
  a_ack_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.kind |=> out_ch.valid && !out_ch.key_ready)
    else $error("acknowledge did not clear key_ready");

  // A finished frame always leaves a key pending.
  a_done_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == ST_DONE |-> out_ch.key_ready)
    else $error("frame done without key_ready");

  // The bit count never runs past a full frame.
  a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.bits <= BITS_MAX)
    else $error("bit count beyond frame length");

endmodule
